### src/wmc_pkg.sv
// Package for the weather message marker counter.
// Holds marker constants, message type codes and the result entry types.
// No dependencies.
`default_nettype none

package wmc_pkg;

  localparam int NUM_TYPES      = 3;
  localparam int MARKER_LEN     = 4;
  localparam int LEN_BYTES      = 3;
  localparam int OUT_COUNT_BITS = 20;
  localparam int LENGTH_BITS    = 24;
  localparam int SUM_BITS       = 32;

  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    MSG_GRIB = 2'd0,
    MSG_BUFR = 2'd1,
    MSG_BLOK = 2'd2
  } msg_type_t;

  // Work for one accepted byte: an optional record and an optional summary.
  typedef struct packed {
    logic                      has_rec;
    logic                      has_sum;
    logic [1:0]                msg_type;
    logic [LENGTH_BITS-1:0]    msg_len;
    logic [OUT_COUNT_BITS-1:0] grib_count;
    logic [OUT_COUNT_BITS-1:0] bufr_count;
    logic [OUT_COUNT_BITS-1:0] blok_count;
    logic [SUM_BITS-1:0]       length_sum;
    logic                      too_short;
  } entry_t;

  function automatic logic [7:0] marker_char(input msg_type_t kind, input logic [1:0] pos);
    logic [31:0] word;
    unique case (kind)
      MSG_GRIB: word = "GRIB";
      MSG_BUFR: word = "BUFR";
      MSG_BLOK: word = "BLOK";
      default:  word = '0;
    endcase
    unique case (pos)
      2'd0:    return word[31:24];
      2'd1:    return word[23:16];
      2'd2:    return word[15:8];
      default: return word[7:0];
    endcase
  endfunction

endpackage

`default_nettype wire

### src/wmc_in_if.sv
// Byte input channel of the weather message marker counter.
// Depends on nothing beyond the valid/ready handshake.
`default_nettype none

interface wmc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

### src/wmc_out_if.sv
// Result channel of the weather message marker counter.
// Depends on wmc_pkg for field widths.
`default_nettype none

interface wmc_out_if import wmc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      record_kind;
  logic [1:0]                message_type;
  logic [LENGTH_BITS-1:0]    body_length;
  logic                      odd_length;
  logic [OUT_COUNT_BITS-1:0] grib_count;
  logic [OUT_COUNT_BITS-1:0] bufr_count;
  logic [OUT_COUNT_BITS-1:0] blok_count;
  logic [SUM_BITS-1:0]       length_sum;
  logic                      too_short;
  logic                      last_result;

  modport source (
    output valid, output record_kind, output message_type, output body_length,
    output odd_length, output grib_count, output bufr_count, output blok_count,
    output length_sum, output too_short, output last_result, input ready
  );
  modport sink (
    input valid, input record_kind, input message_type, input body_length,
    input odd_length, input grib_count, input bufr_count, input blok_count,
    input length_sum, input too_short, input last_result, output ready
  );
endinterface

`default_nettype wire

### src/wmc_scan.sv
// Scanner: marker matchers, length capture, counters and running total.
// Depends on wmc_pkg; produces at most one entry_t per accepted byte.
`default_nettype none

module wmc_scan import wmc_pkg::*; #(
  parameter int COUNT_BITS       = 20,
  parameter int MIN_STREAM_BYTES = 10
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_stream,
  output entry_t          entry,
  output logic            entry_valid
);

  localparam int SEEN_BITS = $clog2(MIN_STREAM_BYTES + 1);

  logic [1:0]             prog       [NUM_TYPES];
  logic [1:0]             prog_next  [NUM_TYPES];
  logic [COUNT_BITS-1:0]  counts     [NUM_TYPES];
  logic [COUNT_BITS-1:0]  counts_next[NUM_TYPES];
  logic [31:0]            cnt_wide   [NUM_TYPES];
  logic [NUM_TYPES-1:0]   done;
  logic [NUM_TYPES-1:0]   hit;
  logic [NUM_TYPES-1:0]   first_hit;
  logic [1:0]             phase, phase_next;
  logic [1:0]             pending, pending_next;
  logic [LENGTH_BITS-1:0] shift, shift_next;
  logic [LENGTH_BITS-1:0] cap;
  logic [SUM_BITS-1:0]    total, total_next;
  logic [SUM_BITS:0]      sum_wide;
  logic [SEEN_BITS-1:0]   seen, seen_next;
  logic                   short_stream;

  always_comb begin
    for (int t = 0; t < NUM_TYPES; t++) begin
      hit[t]       = data_byte == marker_char(msg_type_t'(t[1:0]), prog[t]);
      first_hit[t] = data_byte == marker_char(msg_type_t'(t[1:0]), 2'd0);
      done[t]      = hit[t] && (prog[t] == 2'(MARKER_LEN - 1));
    end
  end

  always_comb begin
    seen_next    = (seen < SEEN_BITS'(MIN_STREAM_BYTES)) ? seen + 1'b1 : seen;
    short_stream = seen_next < SEEN_BITS'(MIN_STREAM_BYTES);
    cap          = {shift[LENGTH_BITS-9:0], data_byte};
    sum_wide     = {1'b0, total} + {{(SUM_BITS + 1 - LENGTH_BITS){1'b0}}, cap};

    phase_next   = phase;
    pending_next = pending;
    shift_next   = shift;
    total_next   = total;
    counts_next  = counts;
    entry        = '0;

    if (phase != 2'd0) begin
      if (phase == 2'(LEN_BYTES)) begin
        entry.has_rec  = 1'b1;
        entry.msg_type = pending;
        entry.msg_len  = cap;
        total_next     = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
        phase_next     = 2'd0;
        shift_next     = '0;
      end else begin
        phase_next = phase + 2'd1;
        shift_next = cap;
      end
    end

    for (int t = 0; t < NUM_TYPES; t++) begin
      if (hit[t]) begin
        prog_next[t] = prog[t] + 2'd1;
      end else begin
        prog_next[t] = first_hit[t] ? 2'd1 : 2'd0;
      end
    end

    if (|done) begin
      for (int t = 0; t < NUM_TYPES; t++) begin
        prog_next[t] = 2'd0;
        if (done[t]) begin
          counts_next[t] = (&counts[t]) ? counts[t] : counts[t] + 1'b1;
          pending_next   = t[1:0];
        end
      end
      phase_next = 2'd1;
      shift_next = '0;
    end

    for (int t = 0; t < NUM_TYPES; t++) begin
      cnt_wide[t] = 32'(counts_next[t]);
    end

    if (end_of_stream) begin
      entry.has_sum   = 1'b1;
      entry.too_short = short_stream;
      if (!short_stream) begin
        entry.grib_count = cnt_wide[MSG_GRIB][OUT_COUNT_BITS-1:0];
        entry.bufr_count = cnt_wide[MSG_BUFR][OUT_COUNT_BITS-1:0];
        entry.blok_count = cnt_wide[MSG_BLOK][OUT_COUNT_BITS-1:0];
        entry.length_sum = total_next;
      end
    end

    entry_valid = accept && (entry.has_rec || entry.has_sum);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_stream)) begin
      for (int t = 0; t < NUM_TYPES; t++) begin
        prog[t]   <= '0;
        counts[t] <= '0;
      end
      phase   <= '0;
      pending <= '0;
      shift   <= '0;
      total   <= '0;
      seen    <= '0;
    end else if (accept) begin
      prog    <= prog_next;
      counts  <= counts_next;
      phase   <= phase_next;
      pending <= pending_next;
      shift   <= shift_next;
      total   <= total_next;
      seen    <= seen_next;
    end
  end

endmodule

`default_nettype wire

### src/wmc_queue.sv
// Two-entry result queue; each entry yields a record, a summary or both.
// Depends on wmc_pkg for entry_t.
`default_nettype none

module wmc_queue import wmc_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      wr,
  input  wire entry_t                    wr_entry,
  output logic                           full,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           record_kind,
  output logic [1:0]                     message_type,
  output logic [LENGTH_BITS-1:0]         body_length,
  output logic                           odd_length,
  output logic [OUT_COUNT_BITS-1:0]      grib_count,
  output logic [OUT_COUNT_BITS-1:0]      bufr_count,
  output logic [OUT_COUNT_BITS-1:0]      blok_count,
  output logic [SUM_BITS-1:0]            length_sum,
  output logic                           too_short,
  output logic                           last_result
);

  entry_t     q [2];
  entry_t     head;
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  logic       half;
  logic       show_sum;
  logic       take;
  logic       pop;

  assign head      = q[rd_ptr];
  assign full      = count[1];
  assign out_valid = count != 2'd0;
  assign show_sum  = !head.has_rec || half;
  assign take      = out_valid && out_ready;
  assign pop       = take && (show_sum || !head.has_sum);

  always_comb begin
    record_kind    = show_sum ? KIND_SUMMARY : KIND_RECORD;
    message_type   = '0;
    body_length    = '0;
    odd_length     = 1'b0;
    grib_count     = '0;
    bufr_count     = '0;
    blok_count     = '0;
    length_sum     = '0;
    too_short      = 1'b0;
    if (show_sum) begin
      grib_count = head.grib_count;
      bufr_count = head.bufr_count;
      blok_count = head.blok_count;
      length_sum = head.length_sum;
      too_short  = head.too_short;
    end else begin
      message_type   = head.msg_type;
      body_length    = head.msg_len;
      odd_length     = head.msg_len[0];
    end
    last_result = show_sum || !head.has_sum;
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= '0;
      half   <= 1'b0;
    end else begin
      if (wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
        half   <= 1'b0;
      end else if (take) begin
        half <= 1'b1;
      end
      count <= count + {1'b0, wr} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

### src/weather_message_marker_counter_core.sv
// Top level of the weather message marker counter.
// Depends on wmc_pkg, wmc_in_if, wmc_out_if, wmc_scan and wmc_queue.
//
//   channel  | direction | transaction
//   ---------+-----------+-------------------------------------------------
//   in_ch    | sink      | one stream byte with its end flag
//   out_ch   | source    | one message record or one end-of-stream summary
//
// One byte is taken per cycle while the queue is not full; its results enter a two-entry queue.
// A byte that ends a length and the stream gives two results, the record first and then the summary.
// in_ch.ready drops only while both queue entries are held.
// rst is synchronous and clears matchers, counters, total and the queue.
`default_nettype none

module weather_message_marker_counter_core import wmc_pkg::*; #(
  parameter int COUNT_BITS       = 20,
  parameter int MIN_STREAM_BYTES = 10
) (
  input wire logic  clk,
  input wire logic  rst,
  wmc_in_if.sink    in_ch,
  wmc_out_if.source out_ch
);

  entry_t entry;
  logic   entry_valid;
  logic   full;
  logic   accept;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && !full;

  wmc_scan #(
    .COUNT_BITS      (COUNT_BITS),
    .MIN_STREAM_BYTES(MIN_STREAM_BYTES)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (in_ch.data_byte),
    .end_of_stream(in_ch.end_of_stream),
    .entry        (entry),
    .entry_valid  (entry_valid)
  );

  wmc_queue u_queue (
    .clk           (clk),
    .rst           (rst),
    .wr            (entry_valid),
    .wr_entry      (entry),
    .full          (full),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .record_kind   (out_ch.record_kind),
    .message_type  (out_ch.message_type),
    .body_length   (out_ch.body_length),
    .odd_length    (out_ch.odd_length),
    .grib_count    (out_ch.grib_count),
    .bufr_count    (out_ch.bufr_count),
    .blok_count    (out_ch.blok_count),
    .length_sum    (out_ch.length_sum),
    .too_short     (out_ch.too_short),
    .last_result   (out_ch.last_result)
  );

endmodule

`default_nettype wire
